### design/mp3br_pkg.sv
// shared types, constants and constant-divide helpers for the mp3 bit reservoir control
package mp3br_pkg;

    // default size of the main data buffer in bits
    localparam int BUFFER_BITS_DEFAULT = 7680;

    // reservoir ceiling limits per mpeg version
    localparam logic [11:0] LIMIT_MPEG1 = 12'd4088;
    localparam logic [11:0] LIMIT_MPEG2 = 12'd2040;

    // saturation value of the reservoir size and of the target
    localparam logic [13:0] SIZE_MAX = 14'h3FFF;

    // reciprocals for constant division
    localparam logic [16:0] RECIP_DIV10 = 17'd52429;  // x / 10 = (x * r) >> 19
    localparam logic [16:0] RECIP_DIV5  = 17'd52429;  // x / 5  = (x * r) >> 18
    localparam logic [16:0] RECIP_DIV3  = 17'd43691;  // x / 3  = (x * r) >> 17

    // event kinds
    typedef enum logic [1:0] {
        KIND_FRAME_BEGIN = 2'd0,
        KIND_GR_QUERY    = 2'd1,
        KIND_GR_ADJUST   = 2'd2,
        KIND_FRAME_END   = 2'd3
    } kind_t;

    // register indexes
    typedef enum logic [1:0] {
        REG_MPEG_ONE        = 2'd0,
        REG_RES_DISABLED    = 2'd1,
        REG_GRANULES        = 2'd2,
        REG_CHANNELS        = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic       mpeg_one;
        logic       reservoir_disabled;
        logic [1:0] granules_per_frame;
        logic [1:0] channel_count;
    } cfg_t;

    typedef struct packed {
        kind_t       kind;
        logic [12:0] avg_bits;
        logic [13:0] frame_length;
        logic [11:0] granule_bits;
    } item_t;

    typedef struct packed {
        logic [13:0] reservoir_level;
        logic [13:0] stuffing_bits;
        logic [11:0] borrow_bits;
        logic [13:0] target_bits;
        logic [14:0] full_frame_bits;
    } res_t;

    // floor(x / 10), exact for x below 81920
    function automatic logic [13:0] div10(input logic [13:0] x);
        logic [30:0] p;
        p = 31'(x) * 31'(RECIP_DIV10);
        return 14'(p >> 19);
    endfunction

    // floor(x / 5), exact over the whole 14-bit range
    function automatic logic [13:0] div5(input logic [13:0] x);
        logic [30:0] p;
        p = 31'(x) * 31'(RECIP_DIV5);
        return 14'(p >> 18);
    endfunction

    // floor(x / 3), exact over the whole 13-bit range
    function automatic logic [12:0] div3(input logic [12:0] x);
        logic [29:0] p;
        p = 30'(x) * 30'(RECIP_DIV3);
        return 13'(p >> 17);
    endfunction

endpackage

### design/mp3_bit_reservoir_control.sv
// top level of the mp3 layer iii bit reservoir control
// Each event on the slave stream (frame begin, granule query, granule adjust,
// frame end, selected by s_tuser) yields exactly one result transaction on the
// master stream, in order. An accepted event is held in an input register; when
// the result register is free or being emptied, a single pass of short arithmetic
// against the reservoir size and ceiling registers updates that state and loads
// the result register, from which the result is offered. Input and output
// registers are decoupled, so one event is taken every cycle while the master
// side keeps up; the state loop is closed within that one pass, so a following
// event always sees the state its predecessor left. The apb port holds the
// version, disable, granule count and channel count registers at byte addresses
// 0, 4, 8 and 12 and must only be written while no event is in flight. The
// reservoir size saturates at zero and at 16383.
module mp3_bit_reservoir_control #(
    parameter int BUFFER_BITS = mp3br_pkg::BUFFER_BITS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    // slave stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // avg_bits[12:0], frame_length[26:13], granule_bits[38:27]
    input  logic [1:0]  s_tuser,   // kind[1:0]
    // master stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // full_frame_bits[14:0], target_bits[28:15],
                                   // borrow_bits[40:29], stuffing_bits[54:41],
                                   // reservoir_level[68:55]
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    mp3br_pkg::cfg_t  cfg;

    // input register
    logic              in_valid_reg;
    logic              in_valid_next;
    mp3br_pkg::item_t  in_item_reg;

    // reservoir state
    logic [13:0]       size_reg;
    logic [13:0]       size_next;
    logic [11:0]       ceiling_reg;
    logic [11:0]       ceiling_next;

    // result register
    logic              out_valid_reg;
    logic              out_valid_next;
    mp3br_pkg::res_t   out_res_reg;
    mp3br_pkg::res_t   res;

    logic              in_xact;
    logic              advance;

    mp3br_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mp3br_calc #(
        .BUFFER_BITS (BUFFER_BITS)
    ) u_calc (
        .cfg          (cfg),
        .item         (in_item_reg),
        .size         (size_reg),
        .ceiling      (ceiling_reg),
        .size_next    (size_next),
        .ceiling_next (ceiling_next),
        .res          (res)
    );

    // the held event moves on when the result register is free or being emptied
    assign advance  = in_valid_reg & (~out_valid_reg | m_tready);
    assign s_tready = ~in_valid_reg | advance;
    assign in_xact  = s_tvalid & s_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_xact)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control and state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            size_reg      <= 14'd0;
            ceiling_reg   <= 12'd0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                size_reg    <= size_next;
                ceiling_reg <= ceiling_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_xact)
        begin
            in_item_reg.kind         <= mp3br_pkg::kind_t'(s_tuser);
            in_item_reg.avg_bits     <= s_tdata[12:0];
            in_item_reg.frame_length <= s_tdata[26:13];
            in_item_reg.granule_bits <= s_tdata[38:27];
        end
        if (advance)
        begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_res_reg};

endmodule

### design/mp3br_cfg.sv
// apb register file for the reservoir control configuration
module mp3br_cfg (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output mp3br_pkg::cfg_t    cfg
);

    mp3br_pkg::cfg_t    cfg_reg;
    mp3br_pkg::cfg_t    cfg_next;
    mp3br_pkg::reg_idx_t idx;
    logic               wr_en;

    assign pready = 1'b1;
    assign idx    = mp3br_pkg::reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel & penable & pwrite & pready;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                mp3br_pkg::REG_MPEG_ONE:     cfg_next.mpeg_one           = pwdata[0];
                mp3br_pkg::REG_RES_DISABLED: cfg_next.reservoir_disabled = pwdata[0];
                mp3br_pkg::REG_GRANULES:     cfg_next.granules_per_frame = pwdata[1:0];
                mp3br_pkg::REG_CHANNELS:     cfg_next.channel_count      = pwdata[1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mpeg_one           <= 1'b1;
            cfg_reg.reservoir_disabled <= 1'b0;
            cfg_reg.granules_per_frame <= 2'd2;
            cfg_reg.channel_count      <= 2'd2;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        unique case (idx)
            mp3br_pkg::REG_MPEG_ONE:     prdata = {31'd0, cfg_reg.mpeg_one};
            mp3br_pkg::REG_RES_DISABLED: prdata = {31'd0, cfg_reg.reservoir_disabled};
            mp3br_pkg::REG_GRANULES:     prdata = {30'd0, cfg_reg.granules_per_frame};
            mp3br_pkg::REG_CHANNELS:     prdata = {30'd0, cfg_reg.channel_count};
        endcase
    end

endmodule

### design/mp3br_calc.sv
// single-pass event arithmetic: next reservoir state and the result item
module mp3br_calc #(
    parameter int BUFFER_BITS = mp3br_pkg::BUFFER_BITS_DEFAULT
) (
    input  mp3br_pkg::cfg_t  cfg,
    input  mp3br_pkg::item_t item,
    input  logic [13:0]      size,
    input  logic [11:0]      ceiling,
    output logic [13:0]      size_next,
    output logic [11:0]      ceiling_next,
    output mp3br_pkg::res_t  res
);

    localparam logic [13:0] BufBits = 14'(BUFFER_BITS);

    // frame begin
    logic [13:0] span;
    logic [11:0] limit;
    logic [11:0] ceil_new;
    logic [14:0] mean_x_gr;
    logic [11:0] usable;

    // granule query
    logic [11:0] t9;
    logic [11:0] t6;
    logic [13:0] add;
    logic [14:0] targ_sum;
    logic [13:0] targ;
    logic [13:0] avail;
    logic [12:0] mean_90;

    // granule adjust
    logic [12:0] share;
    logic [14:0] adj_sum;
    logic [14:0] adj_diff;
    logic [13:0] adj_size;

    // frame end
    logic [13:0] end_size;
    logic [13:0] over;
    logic [13:0] kept;
    logic [13:0] stuff;

    always_comb
    begin
        // ceiling from the frame length, version limit and disable flag
        span     = (item.frame_length <= BufBits) ? BufBits - item.frame_length : 14'd0;
        if (cfg.reservoir_disabled)
        begin
            span = 14'd0;
        end
        limit    = cfg.mpeg_one ? mp3br_pkg::LIMIT_MPEG1 : mp3br_pkg::LIMIT_MPEG2;
        ceil_new = (span < {2'b00, limit}) ? span[11:0] : limit;
        mean_x_gr = 15'(item.avg_bits) * 15'(cfg.granules_per_frame);
        usable   = (size < {2'b00, ceil_new}) ? size[11:0] : ceil_new;

        // 90% and 60% of the ceiling, floor(9c/10) = c - ceil(c/10)
        t9      = ceiling - 12'(mp3br_pkg::div10(14'(ceiling) + 14'd9));
        t6      = 12'(mp3br_pkg::div5(14'({ceiling, 1'b0}) + 14'(ceiling)));
        mean_90 = item.avg_bits - 13'(mp3br_pkg::div10(14'(item.avg_bits) + 14'd9));
        if (size > 14'(t9))
        begin
            add      = size - 14'(t9);
            targ_sum = 15'(item.avg_bits) + 15'(add);
            targ     = (targ_sum > 15'(mp3br_pkg::SIZE_MAX)) ? mp3br_pkg::SIZE_MAX
                                                              : targ_sum[13:0];
        end
        else
        begin
            add      = 14'd0;
            targ_sum = 15'(mean_90);
            targ     = 14'(mean_90);
        end
        avail = (size < 14'(t6)) ? size : 14'(t6);

        // per-channel share of the mean, zero channels taken as one
        case (cfg.channel_count)
            2'd2:    share = item.avg_bits >> 1;
            2'd3:    share = mp3br_pkg::div3(item.avg_bits);
            default: share = item.avg_bits;
        endcase
        adj_sum  = 15'(size) + 15'(share);
        adj_diff = (adj_sum <= 15'(item.granule_bits)) ? 15'd0
                                                       : adj_sum - 15'(item.granule_bits);
        adj_size = (adj_diff > 15'(mp3br_pkg::SIZE_MAX)) ? mp3br_pkg::SIZE_MAX
                                                         : adj_diff[13:0];

        // odd-bit correction, drain above the ceiling, byte-align the rest
        end_size = size;
        if (cfg.channel_count == 2'd2 && item.avg_bits[0] && size < mp3br_pkg::SIZE_MAX)
        begin
            end_size = size + 14'd1;
        end
        over  = (end_size > 14'(ceiling)) ? end_size - 14'(ceiling) : 14'd0;
        kept  = end_size - over;
        stuff = over + {11'd0, kept[2:0]};
    end

    always_comb
    begin
        size_next    = size;
        ceiling_next = ceiling;
        res          = '0;
        unique case (item.kind)
            mp3br_pkg::KIND_FRAME_BEGIN:
            begin
                ceiling_next        = ceil_new;
                res.full_frame_bits = mean_x_gr + 15'(usable);
            end
            mp3br_pkg::KIND_GR_QUERY:
            begin
                res.target_bits = targ;
                res.borrow_bits = (avail > add) ? 12'(avail - add) : 12'd0;
            end
            mp3br_pkg::KIND_GR_ADJUST:
            begin
                size_next = adj_size;
            end
            mp3br_pkg::KIND_FRAME_END:
            begin
                size_next         = end_size - stuff;
                res.stuffing_bits = stuff;
            end
        endcase
        res.reservoir_level = size_next;
    end

endmodule

### sim/mp3_bit_reservoir_control_test.sv
// self-checking testbench for the mp3 bit reservoir control: directed table, then random frames
`timescale 1ns / 1ps

module mp3_bit_reservoir_control_test;

    localparam int BUFFER_BITS = mp3br_pkg::BUFFER_BITS_DEFAULT;

    // one row of the directed table; typed rows carry their expected result
    typedef struct {
        mp3br_pkg::kind_t kind;
        int unsigned      mean;
        int unsigned      flen;
        int unsigned      used;
        bit               typed;
        mp3br_pkg::res_t  want;
    } dir_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;    // avg_bits[12:0], frame_length[26:13], granule_bits[38:27]
    logic [1:0]  s_tuser = '0;    // kind[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b1;
    logic [71:0] m_tdata;         // full_frame_bits[14:0], target_bits[28:15],
                                  // borrow_bits[40:29], stuffing_bits[54:41],
                                  // reservoir_level[68:55]
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // shadow copy of the block's registers and state
    mp3br_pkg::cfg_t shadow_cfg = mp3br_pkg::cfg_t'{1'b1, 1'b0, 2'd2, 2'd2};
    logic [13:0]     shadow_size = '0;
    logic [11:0]     shadow_ceiling = '0;

    mp3br_pkg::res_t results_due[$];
    dir_row_t        dir_rows[$];
    int              err_count = 0;
    int              sent_count = 0;
    int              send_idle_pct = 0;
    int              recv_stall_pct = 0;

    // per-phase idling and register settings
    int   phase_send_pct[4] = '{0, 72, 0, 14};
    int   phase_recv_pct[4] = '{0, 0, 72, 14};
    mp3br_pkg::cfg_t phase_cfg[4] = '{
        mp3br_pkg::cfg_t'{1'b1, 1'b0, 2'd2, 2'd2},
        mp3br_pkg::cfg_t'{1'b0, 1'b0, 2'd1, 2'd1},
        mp3br_pkg::cfg_t'{1'b1, 1'b1, 2'd3, 2'd0},
        mp3br_pkg::cfg_t'{1'b0, 1'b0, 2'd0, 2'd3}
    };

    mp3_bit_reservoir_control DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #2 clk = ~clk;

    // hard stop should the block hang
    initial
    begin
        #2000000;
        $display("[mp3_bit_reservoir_control] ERROR");
        $finish;
    end

    // advance the shadow reservoir by one event and return the result it should give
    function automatic mp3br_pkg::res_t step_reservoir(input mp3br_pkg::item_t ev);
        mp3br_pkg::res_t r;
        int unsigned mean, flen, used, lim, ceil_v, t9, t6, add, avail, targ;
        int unsigned ch, sum, sz, over, stuff;
        r = '0;
        mean = 32'(ev.avg_bits);
        flen = 32'(ev.frame_length);
        used = 32'(ev.granule_bits);
        case (ev.kind)
            mp3br_pkg::KIND_FRAME_BEGIN:
            begin
                lim = shadow_cfg.mpeg_one ? 32'(mp3br_pkg::LIMIT_MPEG1)
                                          : 32'(mp3br_pkg::LIMIT_MPEG2);
                ceil_v = (flen <= BUFFER_BITS) ? BUFFER_BITS - flen : 0;
                if (shadow_cfg.reservoir_disabled)
                    ceil_v = 0;
                shadow_ceiling = 12'((ceil_v < lim) ? ceil_v : lim);
                r.full_frame_bits = 15'(mean * shadow_cfg.granules_per_frame
                    + ((shadow_size < shadow_ceiling) ? shadow_size : shadow_ceiling));
            end
            mp3br_pkg::KIND_GR_QUERY:
            begin
                t9 = (shadow_ceiling * 9) / 10;
                t6 = (shadow_ceiling * 6) / 10;
                add = 0;
                if (shadow_size > t9)
                begin
                    add = shadow_size - t9;
                    targ = mean + add;
                end
                else
                    targ = (mean * 9) / 10;
                if (targ > mp3br_pkg::SIZE_MAX)
                    targ = 32'(mp3br_pkg::SIZE_MAX);
                avail = (shadow_size < t6) ? 32'(shadow_size) : t6;
                r.target_bits = 14'(targ);
                r.borrow_bits = 12'((avail > add) ? avail - add : 0);
            end
            mp3br_pkg::KIND_GR_ADJUST:
            begin
                // a channel count of zero divides as one
                ch = (shadow_cfg.channel_count == 0) ? 1 : 32'(shadow_cfg.channel_count);
                sum = shadow_size + mean / ch;
                sum = (sum <= used) ? 0 : sum - used;
                if (sum > mp3br_pkg::SIZE_MAX)
                    sum = 32'(mp3br_pkg::SIZE_MAX);
                shadow_size = 14'(sum);
            end
            default:
            begin
                sz = 32'(shadow_size);
                // odd-bit correction for stereo, not past the ceiling of the counter
                if (shadow_cfg.channel_count == 2 && mean[0] && sz < mp3br_pkg::SIZE_MAX)
                    sz = sz + 1;
                over = (sz > shadow_ceiling) ? sz - shadow_ceiling : 0;
                stuff = over + ((sz - over) & 7);
                r.stuffing_bits = 14'(stuff);
                shadow_size = 14'(sz - stuff);
            end
        endcase
        r.reservoir_level = shadow_size;
        return r;
    endfunction

    // random event content; the used bits mostly hover around the channel share
    function automatic mp3br_pkg::item_t make_event(input mp3br_pkg::kind_t k,
                                                    input int unsigned mean);
        mp3br_pkg::item_t ev;
        int unsigned share;
        int          g;
        share = mean / ((shadow_cfg.channel_count == 0) ? 1 : shadow_cfg.channel_count);
        ev.kind = k;
        ev.avg_bits = 13'(mean);
        case ($urandom_range(0, 7))
            0:       ev.frame_length = 14'($urandom_range(0, 16383));
            1:       ev.frame_length = 14'($urandom_range(7600, 7760));
            default: ev.frame_length = 14'($urandom_range(600, 7680));
        endcase
        g = int'(share) + int'($urandom_range(0, 1200)) - 600;
        if (g < 0)
            g = 0;
        if (g > 4095)
            g = 4095;
        ev.granule_bits = ($urandom_range(0, 5) == 0) ? 12'($urandom_range(0, 4095)) : 12'(g);
        return ev;
    endfunction

    function automatic void check_field(input string fname, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            err_count++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, fname, want, got);
        end
    endfunction

    // offer one event, optionally after a random gap, and book its result on acceptance
    task automatic push_event(input mp3br_pkg::item_t ev, input bit typed,
                              input mp3br_pkg::res_t want);
        mp3br_pkg::res_t predicted;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= ev.kind;
        s_tdata  <= {1'b0, ev.granule_bits, ev.frame_length, ev.avg_bits};
        do
            @(posedge clk);
        while (!s_tready);
        predicted = step_reservoir(ev);
        results_due.push_back(typed ? want : predicted);
        sent_count++;
    endtask

    // stop sending and let every booked result come back
    task automatic settle();
        s_tvalid <= 1'b0;
        while (results_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic apb_write(input mp3br_pkg::reg_idx_t idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        case (idx)
            mp3br_pkg::REG_MPEG_ONE:     shadow_cfg.mpeg_one = value[0];
            mp3br_pkg::REG_RES_DISABLED: shadow_cfg.reservoir_disabled = value[0];
            mp3br_pkg::REG_GRANULES:     shadow_cfg.granules_per_frame = value[1:0];
            default:                     shadow_cfg.channel_count = value[1:0];
        endcase
    endtask

    task automatic add_row(input mp3br_pkg::kind_t k, input int unsigned mean,
                           input int unsigned flen,
                           input int unsigned used, input bit typed,
                           input int unsigned full, input int unsigned targ,
                           input int unsigned extra, input int unsigned stuff,
                           input int unsigned level);
        dir_row_t row;
        row.kind  = k;
        row.mean  = mean;
        row.flen  = flen;
        row.used  = used;
        row.typed = typed;
        row.want  = mp3br_pkg::res_t'{14'(level), 14'(stuff), 12'(extra), 14'(targ),
                                      15'(full)};
        dir_rows.push_back(row);
    endtask

    // receiver back-pressure
    always @(posedge clk)
        m_tready <= ($urandom_range(0, 99) < recv_stall_pct) ? 1'b0 : 1'b1;

    // every result transaction is compared against the oldest booked one
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin : compare_result
            mp3br_pkg::res_t got;
            mp3br_pkg::res_t want;
            got = mp3br_pkg::res_t'(m_tdata[68:0]);
            if (results_due.size() == 0)
            begin
                err_count++;
                $display("%0t: unexpected result, expected none, got %h", $time, got);
            end
            else
            begin
                want = results_due.pop_front();
                check_field("full_frame_bits", want.full_frame_bits, got.full_frame_bits);
                check_field("target_bits", want.target_bits, got.target_bits);
                check_field("borrow_bits", want.borrow_bits, got.borrow_bits);
                check_field("stuffing_bits", want.stuffing_bits, got.stuffing_bits);
                check_field("reservoir_level", want.reservoir_level, got.reservoir_level);
            end
        end
    end

    initial
    begin : stimulus
        mp3br_pkg::item_t ev;
        int unsigned mean;
        int          gr;
        int          ch;
        bit          held;
        held = 1'b0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part, from the reset settings: mpeg-1, reservoir on, two granules, stereo
        // query on an empty reservoir: target is nine tenths of the mean
        add_row(mp3br_pkg::KIND_GR_QUERY,    8191,     0,    0, 1,     0, 7371, 0, 0, 0);
        add_row(mp3br_pkg::KIND_GR_QUERY,       0, 16383, 4095, 1,     0,    0, 0, 0, 0);
        // frame end on an empty reservoir, even mean then odd-bit correction
        add_row(mp3br_pkg::KIND_FRAME_END,   8190,     0,    0, 1,     0,    0, 0, 0, 0);
        add_row(mp3br_pkg::KIND_FRAME_END,      1,     0,    0, 1,     0,    0, 0, 1, 0);
        // widest ceiling, budget is just the mean times two
        add_row(mp3br_pkg::KIND_FRAME_BEGIN, 8191,     0,    0, 1, 16382,    0, 0, 0, 0);
        // fill the reservoir up to its top and push it into saturation
        repeat (5)
            add_row(mp3br_pkg::KIND_GR_ADJUST, 8191,   0,    0, 0, 0, 0, 0, 0, 0);
        // target saturation on a full reservoir
        add_row(mp3br_pkg::KIND_GR_QUERY,    8191,     0,    0, 0, 0, 0, 0, 0, 0);
        // drain of the excess, odd mean but counter already at its top
        add_row(mp3br_pkg::KIND_FRAME_END,      3,     0,    0, 0, 0, 0, 0, 0, 0);
        // frame longer than the buffer gives a zero ceiling
        add_row(mp3br_pkg::KIND_FRAME_BEGIN,  100, 16383,    0, 0, 0, 0, 0, 0, 0);
        add_row(mp3br_pkg::KIND_FRAME_END,      0,     0,    0, 0, 0, 0, 0, 0, 0);
        // size saturating at zero
        add_row(mp3br_pkg::KIND_GR_ADJUST,   2000,     0,    0, 0, 0, 0, 0, 0, 0);
        add_row(mp3br_pkg::KIND_GR_ADJUST,      0,     0, 4095, 0, 0, 0, 0, 0, 0);
        // ceiling edges: exactly the buffer, one below, exactly the limit, past the limit
        add_row(mp3br_pkg::KIND_FRAME_BEGIN,    0,  7680,    0, 0, 0, 0, 0, 0, 0);
        add_row(mp3br_pkg::KIND_FRAME_BEGIN,    0,  7679,    0, 0, 0, 0, 0, 0, 0);
        add_row(mp3br_pkg::KIND_FRAME_BEGIN,    0,  3592,    0, 0, 0, 0, 0, 0, 0);
        add_row(mp3br_pkg::KIND_FRAME_BEGIN,    0,  3591,    0, 0, 0, 0, 0, 0, 0);
        add_row(mp3br_pkg::KIND_GR_ADJUST,    100,     0,    7, 0, 0, 0, 0, 0, 0);
        add_row(mp3br_pkg::KIND_GR_QUERY,    1000,     0,    0, 0, 0, 0, 0, 0, 0);
        add_row(mp3br_pkg::KIND_FRAME_END,      5,     0,    0, 0, 0, 0, 0, 0, 0);
        add_row(mp3br_pkg::KIND_GR_QUERY,    5000,     0,    0, 0, 0, 0, 0, 0, 0);

        foreach (dir_rows[i])
        begin
            ev.kind         = dir_rows[i].kind;
            ev.avg_bits     = 13'(dir_rows[i].mean);
            ev.frame_length = 14'(dir_rows[i].flen);
            ev.granule_bits = 12'(dir_rows[i].used);
            push_event(ev, dir_rows[i].typed, dir_rows[i].want);
        end

        // random part: one register setting and one idling pattern per phase
        for (int phase = 0; phase < 4; phase++)
        begin
            settle();
            apb_write(mp3br_pkg::REG_MPEG_ONE,     {31'd0, phase_cfg[phase].mpeg_one});
            apb_write(mp3br_pkg::REG_RES_DISABLED,
                      {31'd0, phase_cfg[phase].reservoir_disabled});
            apb_write(mp3br_pkg::REG_GRANULES,
                      {30'd0, phase_cfg[phase].granules_per_frame});
            apb_write(mp3br_pkg::REG_CHANNELS,     {30'd0, phase_cfg[phase].channel_count});
            send_idle_pct  = phase_send_pct[phase];
            recv_stall_pct = phase_recv_pct[phase];
            sent_count = 0;
            gr = (shadow_cfg.granules_per_frame == 0) ? 1 : shadow_cfg.granules_per_frame;
            ch = (shadow_cfg.channel_count == 0) ? 1 : shadow_cfg.channel_count;
            while (sent_count < 100)
            begin
                if ($urandom_range(0, 4) == 0)
                begin
                    // stray event of any kind with a fully random mean
                    ev = make_event(mp3br_pkg::kind_t'($urandom_range(0, 3)),
                                    $urandom_range(0, 8191));
                    push_event(ev, 1'b0, '0);
                end
                else
                begin
                    // well-formed frame: begin, query and adjust per granule channel, end
                    mean = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8191)
                                                       : $urandom_range(200, 3000);
                    push_event(make_event(mp3br_pkg::KIND_FRAME_BEGIN, mean), 1'b0, '0);
                    for (int g = 0; g < gr; g++)
                    begin
                        for (int c = 0; c < ch; c++)
                        begin
                            push_event(make_event(mp3br_pkg::KIND_GR_QUERY, mean), 1'b0, '0);
                            push_event(make_event(mp3br_pkg::KIND_GR_ADJUST, mean), 1'b0, '0);
                        end
                    end
                    push_event(make_event(mp3br_pkg::KIND_FRAME_END, mean), 1'b0, '0);
                end
                // once, hold the sender until the result stream has run dry
                if (phase == 1 && !held && sent_count >= 50)
                begin
                    held = 1'b1;
                    settle();
                end
            end
        end

        settle();
        repeat (8) @(posedge clk);
        if (err_count == 0)
            $display("[mp3_bit_reservoir_control] OK");
        else
            $display("[mp3_bit_reservoir_control] ERROR");
        $finish;
    end

endmodule

### files.f
design/mp3br_pkg.sv
design/mp3br_cfg.sv
design/mp3br_calc.sv
design/mp3_bit_reservoir_control.sv
sim/mp3_bit_reservoir_control_test.sv
